FILE: design/dxtbd_pkg.sv
`default_nettype none
package dxtbd_pkg;

  // Largest image side in pixels.
  localparam int MaxDim = 4096;
  localparam int DimW = $clog2(MaxDim + 1);
  localparam int BlkW = $clog2(MaxDim) - 2;

  localparam int CfgDimW = 13;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 13;
  localparam int CoordW = 12;

  localparam int Lanes = 16;
  localparam int LaneIdxW = $clog2(Lanes);

  localparam logic [CfgIdxW-1:0] CfgFormat = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd2;

  localparam logic [1:0] ModeDxt1 = 2'd0;
  localparam logic [1:0] ModeDxt3 = 2'd1;
  localparam logic [1:0] ModeDxt5 = 2'd2;

  typedef struct packed {
    logic [63:0] color_word;
    logic [63:0] alpha_word;
  } in_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic has_transparency;
    logic last_of_block;
  } out_t;

  typedef struct packed {
    logic [3:0][7:0] r;
    logic [3:0][7:0] g;
    logic [3:0][7:0] b;
    logic three;
    logic [7:0][7:0] a;
  } pal_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic transp;
  } pix_t;

  typedef struct packed {
    pix_t [Lanes-1:0] pix;
    logic [Lanes-1:0] mask;
    logic clear;
    logic [BlkW-1:0] col;
    logic [BlkW-1:0] row;
  } blk_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [CfgDimW-1:0] d);
    logic [DimW-1:0] r;
    if (d == '0) begin
      r = DimW'(1);
    end else if (32'(d) > 32'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = DimW'(d);
    end
    return r;
  endfunction

  // Division by small constants as reciprocal multiplies; exact over the
  // value ranges the palettes produce.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = {13'd0, x} * 24'd1639;
    return p[20:13];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

endpackage
`default_nettype wire

FILE: design/dxtbd_palette.sv
`default_nettype none
module dxtbd_palette (
  input  wire logic [1:0]    mode_i,
  input  wire logic [15:0]   c0_i,
  input  wire logic [15:0]   c1_i,
  input  wire logic [7:0]    a0_i,
  input  wire logic [7:0]    a1_i,
  output dxtbd_pkg::pal_t    pal_o
);

  logic [2:0][7:0] e0;
  logic [2:0][7:0] e1;
  logic [10:0] t;

  always_comb begin
    // Endpoints expand by a plain left shift, channel order r, g, b.
    e0[0] = {c0_i[15:11], 3'b000};
    e0[1] = {c0_i[10:5], 2'b00};
    e0[2] = {c0_i[4:0], 3'b000};
    e1[0] = {c1_i[15:11], 3'b000};
    e1[1] = {c1_i[10:5], 2'b00};
    e1[2] = {c1_i[4:0], 3'b000};

    pal_o = '0;
    pal_o.three = (mode_i == dxtbd_pkg::ModeDxt1) && (c0_i <= c1_i);
    pal_o.r[0] = e0[0];
    pal_o.g[0] = e0[1];
    pal_o.b[0] = e0[2];
    pal_o.r[1] = e1[0];
    pal_o.g[1] = e1[1];
    pal_o.b[1] = e1[2];
    if (!pal_o.three) begin
      pal_o.r[2] = dxtbd_pkg::div3({1'b0, e0[0], 1'b0} + {2'b00, e1[0]} + 10'd1);
      pal_o.g[2] = dxtbd_pkg::div3({1'b0, e0[1], 1'b0} + {2'b00, e1[1]} + 10'd1);
      pal_o.b[2] = dxtbd_pkg::div3({1'b0, e0[2], 1'b0} + {2'b00, e1[2]} + 10'd1);
      pal_o.r[3] = dxtbd_pkg::div3({1'b0, e1[0], 1'b0} + {2'b00, e0[0]} + 10'd1);
      pal_o.g[3] = dxtbd_pkg::div3({1'b0, e1[1], 1'b0} + {2'b00, e0[1]} + 10'd1);
      pal_o.b[3] = dxtbd_pkg::div3({1'b0, e1[2], 1'b0} + {2'b00, e0[2]} + 10'd1);
    end else begin
      pal_o.r[2] = 8'(({1'b0, e0[0]} + {1'b0, e1[0]}) >> 1);
      pal_o.g[2] = 8'(({1'b0, e0[1]} + {1'b0, e1[1]}) >> 1);
      pal_o.b[2] = 8'(({1'b0, e0[2]} + {1'b0, e1[2]}) >> 1);
    end

    pal_o.a[0] = a0_i;
    pal_o.a[1] = a1_i;
    t = '0;
    if (a0_i > a1_i) begin
      for (int i = 1; i <= 6; i++) begin
        t = 11'(7 - i) * {3'b000, a0_i} + 11'(i) * {3'b000, a1_i} + 11'd3;
        pal_o.a[i + 1] = dxtbd_pkg::div7(t);
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        t = 11'(5 - i) * {3'b000, a0_i} + 11'(i) * {3'b000, a1_i} + 11'd2;
        pal_o.a[i + 1] = dxtbd_pkg::div5(t);
      end
      pal_o.a[6] = 8'd0;
      pal_o.a[7] = 8'd255;
    end
  end

endmodule
`default_nettype wire

FILE: design/dxtbd_lane.sv
`default_nettype none
module dxtbd_lane (
  input  wire dxtbd_pkg::pal_t pal_i,
  input  wire logic [1:0]    mode_i,
  input  wire logic [1:0]    cidx_i,
  input  wire logic [3:0]    a4_i,
  input  wire logic [2:0]    aidx_i,
  output dxtbd_pkg::pix_t    pix_o
);

  always_comb begin
    pix_o.r = pal_i.r[cidx_i];
    pix_o.g = pal_i.g[cidx_i];
    pix_o.b = pal_i.b[cidx_i];
    unique case (mode_i)
      dxtbd_pkg::ModeDxt1: begin
        // In three-color mode the last entry is transparent black.
        if (pal_i.three && cidx_i == 2'd3) begin
          pix_o.r = 8'd0;
          pix_o.g = 8'd0;
          pix_o.b = 8'd0;
          pix_o.a = 8'd0;
          pix_o.transp = 1'b1;
        end else begin
          pix_o.a = 8'd255;
          pix_o.transp = 1'b0;
        end
      end
      dxtbd_pkg::ModeDxt3: begin
        pix_o.a = {a4_i, 4'b0000};
        pix_o.transp = (a4_i != 4'd15);
      end
      default: begin
        pix_o.a = pal_i.a[aidx_i];
        pix_o.transp = (pal_i.a[aidx_i] < 8'd240);
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/dxtbd_merge.sv
`default_nettype none
module dxtbd_merge (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        blk_valid_i,
  input  wire dxtbd_pkg::blk_t blk_i,
  output logic             blk_take_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output dxtbd_pkg::out_t  out_data_o
);

  dxtbd_pkg::blk_t bank_q;
  logic [dxtbd_pkg::Lanes-1:0] mask_q, mask_d;
  logic [dxtbd_pkg::Lanes-1:0] low, rest;
  logic [dxtbd_pkg::LaneIdxW-1:0] idx;
  dxtbd_pkg::pix_t psel;
  logic seen_q, seen_d;
  logic out_valid_q;
  dxtbd_pkg::out_t out_q;
  logic pop, out_free;

  always_comb begin
    low = mask_q & (~mask_q + 1'b1);
    rest = mask_q & ~low;
    idx = '0;
    psel = '0;
    for (int k = 0; k < dxtbd_pkg::Lanes; k++) begin
      if (low[k]) begin
        idx = dxtbd_pkg::LaneIdxW'(k);
        psel = bank_q.pix[k];
      end
    end
    out_free = !out_valid_q || !out_stall_i;
    pop = (mask_q != '0) && out_free;
    // A new block may load in the cycle that sends the last word of the
    // previous one.
    blk_take_o = blk_valid_i && ((mask_q == '0) || (pop && rest == '0));

    if (blk_take_o) begin
      mask_d = blk_i.mask;
    end else if (pop) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end

    if (blk_take_o && blk_i.clear) begin
      seen_d = 1'b0;
    end else begin
      seen_d = seen_q | (pop & psel.transp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      seen_q <= seen_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_take_o) begin
      bank_q <= blk_i;
    end
    if (pop) begin
      out_q.pixel_x <= dxtbd_pkg::CoordW'({bank_q.col, idx[1:0]});
      out_q.pixel_y <= dxtbd_pkg::CoordW'({bank_q.row, idx[3:2]});
      out_q.red <= psel.r;
      out_q.green <= psel.g;
      out_q.blue <= psel.b;
      out_q.alpha <= psel.a;
      out_q.has_transparency <= seen_q | psel.transp;
      out_q.last_of_block <= (rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule
`default_nettype wire

FILE: design/dxt_block_decoder_unit.sv
`default_nettype none
// DXT1/DXT3/DXT5 texture block decoder.
// Input channel (in_valid_i, in_stall_o, in_data_i): one 128-bit compressed
// 4x4 block per word, in raster block order across the image. Output channel
// (out_valid_o, out_stall_i, out_data_o): one decoded pixel per word with its
// image coordinates, in raster order within the block; pixels outside the
// configured width and height are dropped, and last_of_block marks the final
// pixel sent for a block. The configuration port writes the format code and
// the image size; write it only while the block is idle.
// The first pixel of a block is valid once the block has passed the input
// stage, the merge bank and the output register. Sixteen lanes decode a whole
// block in parallel, so throughput is set by the output port: one pixel per
// cycle while out_stall_i is low. The next block is taken while the current
// one is still being sent.
// Reset clears the block position, the sticky transparency flag and the
// pipeline, and sets DXT1 with a 4096 x 4096 image. While out_stall_i is high
// the current pixel holds; one further block waits in the input stage and
// then in_stall_o rises.
module dxt_block_decoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire dxtbd_pkg::in_t                  in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output dxtbd_pkg::out_t                      out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [dxtbd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dxtbd_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [1:0] mode_q;
  logic [dxtbd_pkg::CfgDimW-1:0] width_q, height_q;
  logic [dxtbd_pkg::DimW-1:0] w_cl, h_cl;
  logic [dxtbd_pkg::BlkW:0] bcols, brows;
  logic [dxtbd_pkg::BlkW-1:0] col_q, col_d, row_q, row_d;
  logic [dxtbd_pkg::BlkW:0] col_inc, row_inc;
  logic [dxtbd_pkg::Lanes-1:0] mask_d;
  logic in_accept;

  logic a_valid_q;
  dxtbd_pkg::in_t a_in_q;
  logic [1:0] a_mode_q;
  logic [dxtbd_pkg::Lanes-1:0] a_mask_q;
  logic a_clear_q;
  logic [dxtbd_pkg::BlkW-1:0] a_col_q, a_row_q;

  dxtbd_pkg::pal_t pal;
  dxtbd_pkg::pix_t [dxtbd_pkg::Lanes-1:0] lane_pix;
  dxtbd_pkg::blk_t blk;
  logic blk_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dxtbd_pkg::ModeDxt1;
      width_q <= dxtbd_pkg::CfgDimW'(4096);
      height_q <= dxtbd_pkg::CfgDimW'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dxtbd_pkg::CfgFormat: mode_q <= cfg_data_i[1:0];
        dxtbd_pkg::CfgWidth:  width_q <= cfg_data_i;
        dxtbd_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_cl = dxtbd_pkg::clamp_dim(width_q);
    h_cl = dxtbd_pkg::clamp_dim(height_q);
    bcols = (dxtbd_pkg::BlkW + 1)'(((dxtbd_pkg::DimW + 1)'(w_cl) + 3) >> 2);
    brows = (dxtbd_pkg::BlkW + 1)'(((dxtbd_pkg::DimW + 1)'(h_cl) + 3) >> 2);

    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (col_inc >= bcols) begin
        col_d = '0;
        row_d = (row_inc >= brows) ? '0 : row_inc[dxtbd_pkg::BlkW-1:0];
      end else begin
        col_d = col_inc[dxtbd_pkg::BlkW-1:0];
      end
    end

    // Pixel k sits at column col*4 + k%4 and row row*4 + k/4.
    for (int k = 0; k < dxtbd_pkg::Lanes; k++) begin
      mask_d[k] =
        ((dxtbd_pkg::DimW + 1)'({col_q, 2'(k % 4)}) < (dxtbd_pkg::DimW + 1)'(w_cl)) &&
        ((dxtbd_pkg::DimW + 1)'({row_q, 2'(k / 4)}) < (dxtbd_pkg::DimW + 1)'(h_cl));
    end
  end

  assign in_stall_o = a_valid_q && !blk_take;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_accept) begin
        a_valid_q <= 1'b1;
      end else if (blk_take) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_in_q <= in_data_i;
      a_mode_q <= mode_q;
      a_mask_q <= mask_d;
      a_clear_q <= (col_q == '0) && (row_q == '0);
      a_col_q <= col_q;
      a_row_q <= row_q;
    end
  end

  dxtbd_palette u_palette (
    .mode_i (a_mode_q),
    .c0_i   (a_in_q.color_word[15:0]),
    .c1_i   (a_in_q.color_word[31:16]),
    .a0_i   (a_in_q.alpha_word[7:0]),
    .a1_i   (a_in_q.alpha_word[15:8]),
    .pal_o  (pal)
  );

  for (genvar k = 0; k < dxtbd_pkg::Lanes; k++) begin : g_lane
    dxtbd_lane u_lane (
      .pal_i  (pal),
      .mode_i (a_mode_q),
      .cidx_i (a_in_q.color_word[32 + 2 * k +: 2]),
      .a4_i   (a_in_q.alpha_word[4 * k +: 4]),
      .aidx_i (a_in_q.alpha_word[16 + 3 * k +: 3]),
      .pix_o  (lane_pix[k])
    );
  end

  always_comb begin
    blk.pix = lane_pix;
    blk.mask = a_mask_q;
    blk.clear = a_clear_q;
    blk.col = a_col_q;
    blk.row = a_row_q;
  end

  dxtbd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (a_valid_q),
    .blk_i       (blk),
    .blk_take_o  (blk_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_take_needs_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_take |-> a_valid_q)
    else $error("block taken from an empty input stage");

  a_empty_stage_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> !in_stall_o)
    else $error("input stalled while the input stage is empty");

  a_opaque_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_transparency |-> out_data_o.alpha >= 8'd240)
    else $error("transparent pixel sent without the transparency flag");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> a_valid_q)
    else $error("accepted block did not reach the input stage");

endmodule
`default_nettype wire

FILE: tb/sv/dxt_block_decoder_unit_tb.sv
module dxt_block_decoder_unit_tb;
  import dxtbd_pkg::*;

  // Format code that has no meaning of its own and decodes as DXT5.
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int Phases = 10;
  localparam int BlocksPerPhase = 37;
  localparam int HoldCycles = 300;
  localparam int DrainLimit = 20000;
  localparam int NumRows = 25;

  typedef enum logic {RowCfg, RowBlock} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] data;
    logic [63:0] cw;
    logic [63:0] aw;
    logic typed;
    logic [31:0] rgba;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgFormat;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  // Decoder state as the testbench sees it.
  logic [1:0] cur_fmt = ModeDxt1;
  logic [CfgDimW-1:0] img_w = 13'd4096;
  logic [CfgDimW-1:0] img_h = 13'd4096;
  int unsigned blk_col = 0;
  int unsigned blk_row = 0;
  logic seen_transp = 1'b0;

  out_t pixel_q[$];
  out_t want;
  int fails = 0;
  bit hold_req = 1'b0;
  row_t dir_rows [NumRows];

  dxt_block_decoder_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned fit_dim(input logic [CfgDimW-1:0] d);
    if (d == '0) return 1;
    if (d > MaxDim) return MaxDim;
    return d;
  endfunction

  function automatic int unsigned mix_third(input int unsigned x, input int unsigned y);
    return (2 * x + y + 1) / 3;
  endfunction

  // Expands one compressed block into the pixels it should produce and
  // advances the block position.
  task automatic decode_block(input in_t blk);
    int unsigned w, h, cols, rows, px, py, ci, sel, a;
    int unsigned r[4], g[4], b[4], av[4], apal[8];
    logic [15:0] c0, c1;
    logic three, transp;
    out_t pix;
    int n, k, i;
    w = fit_dim(img_w);
    h = fit_dim(img_h);
    cols = (w + 3) >> 2;
    rows = (h + 3) >> 2;
    c0 = blk.color_word[15:0];
    c1 = blk.color_word[31:16];
    three = (cur_fmt == ModeDxt1) && (c0 <= c1);
    if (blk_col == 0 && blk_row == 0) seen_transp = 1'b0;
    r[0] = {c0[15:11], 3'b000};
    g[0] = {c0[10:5], 2'b00};
    b[0] = {c0[4:0], 3'b000};
    r[1] = {c1[15:11], 3'b000};
    g[1] = {c1[10:5], 2'b00};
    b[1] = {c1[4:0], 3'b000};
    av = '{255, 255, 255, 255};
    if (!three) begin
      r[2] = mix_third(r[0], r[1]);
      g[2] = mix_third(g[0], g[1]);
      b[2] = mix_third(b[0], b[1]);
      r[3] = mix_third(r[1], r[0]);
      g[3] = mix_third(g[1], g[0]);
      b[3] = mix_third(b[1], b[0]);
    end else begin
      r[2] = (r[0] + r[1]) >> 1;
      g[2] = (g[0] + g[1]) >> 1;
      b[2] = (b[0] + b[1]) >> 1;
      r[3] = 0;
      g[3] = 0;
      b[3] = 0;
      av[3] = 0;
    end
    apal[0] = blk.alpha_word[7:0];
    apal[1] = blk.alpha_word[15:8];
    if (apal[0] > apal[1]) begin
      for (i = 1; i <= 6; i++) apal[i + 1] = ((7 - i) * apal[0] + i * apal[1] + 3) / 7;
    end else begin
      for (i = 1; i <= 4; i++) apal[i + 1] = ((5 - i) * apal[0] + i * apal[1] + 2) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    n = 0;
    for (k = 0; k < Lanes; k++) begin
      px = blk_col * 4 + k % 4;
      py = blk_row * 4 + k / 4;
      if (px < w && py < h) begin
        ci = blk.color_word[32 + 2 * k +: 2];
        if (cur_fmt == ModeDxt1) begin
          a = av[ci];
          transp = (a == 0);
        end else if (cur_fmt == ModeDxt3) begin
          sel = blk.alpha_word[4 * k +: 4];
          a = sel << 4;
          transp = (sel < 15);
        end else begin
          sel = blk.alpha_word[16 + 3 * k +: 3];
          a = apal[sel];
          transp = (a < 240);
        end
        if (transp) seen_transp = 1'b1;
        pix.pixel_x = CoordW'(px);
        pix.pixel_y = CoordW'(py);
        pix.red = 8'(r[ci]);
        pix.green = 8'(g[ci]);
        pix.blue = 8'(b[ci]);
        pix.alpha = 8'(a);
        pix.has_transparency = seen_transp;
        pix.last_of_block = 1'b0;
        pixel_q.push_back(pix);
        n++;
      end
    end
    if (n > 0) pixel_q[pixel_q.size() - 1].last_of_block = 1'b1;
    blk_col++;
    if (blk_col >= cols) begin
      blk_col = 0;
      blk_row++;
      if (blk_row >= rows) blk_row = 0;
    end
  endtask

  function automatic in_t rand_block();
    logic [15:0] c0, c1;
    logic [31:0] idx;
    logic [63:0] aw;
    logic [7:0] a0, a1;
    in_t blk;
    c0 = 16'($urandom);
    c1 = ($urandom_range(0, 7) == 0) ? c0 : 16'($urandom);
    idx = $urandom;
    // Indices 0 and 1 only keep a DXT1 image opaque for a while.
    if ($urandom_range(0, 3) == 0) idx = idx & 32'h5555_5555;
    case ($urandom_range(0, 3))
      0: aw = {$urandom, $urandom};
      1: aw = ~(64'($urandom_range(0, 1)) << $urandom_range(0, 63));
      2: begin
        a0 = 8'($urandom_range(1, 255));
        a1 = 8'($urandom_range(0, a0 - 1));
        aw = {$urandom, 16'($urandom), a1, a0};
      end
      default: begin
        a0 = 8'($urandom);
        a1 = 8'($urandom_range(a0, 255));
        aw = {$urandom, 16'($urandom), a1, a0};
      end
    endcase
    blk.color_word = {idx, c1, c0};
    blk.alpha_word = aw;
    return blk;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'h1fff;
      3: return 13'd1;
      default: return CfgDataW'($urandom_range(2, 20));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input out_t exp_pix, input out_t got);
    fails++;
    if (fails <= 10) begin
      $display("%s: want x=%0d y=%0d rgba=%h_%h_%h_%h t=%b l=%b", what,
               exp_pix.pixel_x, exp_pix.pixel_y, exp_pix.red, exp_pix.green,
               exp_pix.blue, exp_pix.alpha, exp_pix.has_transparency,
               exp_pix.last_of_block);
      $display("  got x=%0d y=%0d rgba=%h_%h_%h_%h t=%b l=%b",
               got.pixel_x, got.pixel_y, got.red, got.green, got.blue, got.alpha,
               got.has_transparency, got.last_of_block);
    end
  endtask

  // Offers one word and returns at the edge that accepts it. Valid stays
  // high so that a following word can go out back to back.
  task automatic send_block(input in_t blk, input bit hurry);
    int unsigned gap;
    if (hurry) gap = 0;
    else if ($urandom_range(0, 99) < 60) gap = 0;
    else if ($urandom_range(0, 99) < 80) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= blk;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_pixels();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pixel_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (pixel_q.size() != 0) begin
      fails++;
      $display("%0d expected pixels never arrived", pixel_q.size());
      pixel_q.delete();
    end
    // A block that is wholly clipped sends nothing but may still be in flight.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgFormat: cur_fmt = data[1:0];
      CfgWidth: img_w = data;
      CfgHeight: img_h = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        note_mismatch("unexpected pixel", '0, out_data);
      end else begin
        want = pixel_q.pop_front();
        if (out_data !== want) note_mismatch("pixel mismatch", want, out_data);
      end
    end
  end

  initial begin
    int unsigned len;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= 1'b1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 8);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int i, j, first, ph, nb;
    in_t blk;
    logic [1:0] fmt;
    dir_rows = '{
      '{RowBlock, CfgFormat, 13'd0, 64'h0, 64'h0, 1'b1, 32'h0000_00ff},
      '{RowBlock, CfgFormat, 13'd0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
        1'b1, 32'h0000_0000},
      '{RowCfg, CfgWidth, 13'd5, 64'h0, 64'h0, 1'b0, 32'h0},
      '{RowBlock, CfgFormat, 13'd0, 64'h0000_0000_0000_ffff, 64'h0, 1'b1, 32'hf8fc_f8ff},
      '{RowCfg, CfgHeight, 13'd6, 64'h0, 64'h0, 1'b0, 32'h0},
      '{RowBlock, CfgFormat, 13'd0, 64'h0000_0000_0000_ffff, 64'h0, 1'b1, 32'hf8fc_f8ff},
      '{RowBlock, CfgFormat, 13'd0, 64'h5555_5555_0000_f800, 64'h0, 1'b1, 32'h0000_00ff},
      '{RowBlock, CfgFormat, 13'd0, 64'haaaa_aaaa_001f_f800, 64'hffff_ffff_ffff_ffff,
        1'b1, 32'ha500_53ff},
      '{RowBlock, CfgFormat, 13'd0, 64'hffff_ffff_001f_f800, 64'h0, 1'b1, 32'h5300_a5ff},
      '{RowBlock, CfgFormat, 13'd0, 64'haaaa_aaaa_f800_001f, 64'h0, 1'b1, 32'h7c00_7cff},
      '{RowBlock, CfgFormat, 13'd0, 64'h1b1b_e4e4_7bef_7bef, 64'h0, 1'b0, 32'h0},
      '{RowCfg, CfgWidth, 13'd0, 64'h0, 64'h0, 1'b0, 32'h0},
      '{RowBlock, CfgFormat, 13'd0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
        1'b0, 32'h0},
      '{RowCfg, CfgHeight, 13'h1fff, 64'h0, 64'h0, 1'b0, 32'h0},
      '{RowCfg, CfgFormat, 13'(ModeDxt3), 64'h0, 64'h0, 1'b0, 32'h0},
      '{RowBlock, CfgFormat, 13'd0, 64'h0, 64'hffff_ffff_ffff_ffff, 1'b1, 32'h0000_00f0},
      '{RowBlock, CfgFormat, 13'd0, 64'h0, 64'h0, 1'b1, 32'h0000_0000},
      '{RowBlock, CfgFormat, 13'd0, 64'h9c3a_61e5_07e0_f81f, 64'h0123_4567_89ab_cdef,
        1'b0, 32'h0},
      '{RowCfg, CfgFormat, 13'(ModeDxt5), 64'h0, 64'h0, 1'b0, 32'h0},
      '{RowBlock, CfgFormat, 13'd0, 64'h0, 64'h0000_0000_0000_00ff, 1'b1, 32'h0000_00ff},
      '{RowBlock, CfgFormat, 13'd0, 64'h0, 64'hffff_ffff_ffff_ffff, 1'b1, 32'h0000_00ff},
      '{RowBlock, CfgFormat, 13'd0, 64'h0, 64'hdb6d_b6db_6db6_0000, 1'b1, 32'h0000_0000},
      '{RowBlock, CfgFormat, 13'd0, 64'hc3a5_5a3c_f81f_07e0, 64'h4924_9249_2492_10f0,
        1'b0, 32'h0},
      '{RowCfg, CfgFormat, 13'(ModeUnused), 64'h0, 64'h0, 1'b0, 32'h0},
      '{RowBlock, CfgFormat, 13'd0, 64'hdead_beef_cafe_f00d, 64'h0f1e_2d3c_4b5a_6978,
        1'b0, 32'h0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (i = 0; i < NumRows; i++) begin
      if (dir_rows[i].kind == RowCfg) begin
        drain_pixels();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        blk.color_word = dir_rows[i].cw;
        blk.alpha_word = dir_rows[i].aw;
        send_block(blk, 1'b0);
        first = pixel_q.size();
        decode_block(blk);
        // Rows with a known color take it as written, not as predicted.
        if (dir_rows[i].typed) begin
          for (j = first; j < pixel_q.size(); j++) begin
            {pixel_q[j].red, pixel_q[j].green, pixel_q[j].blue, pixel_q[j].alpha} =
                dir_rows[i].rgba;
          end
        end
      end
    end

    for (ph = 0; ph < Phases; ph++) begin
      drain_pixels();
      fmt = ($urandom_range(0, 7) == 0) ? ModeUnused : 2'($urandom_range(ModeDxt1, ModeDxt5));
      write_reg(CfgFormat, CfgDataW'(fmt));
      // The hold phase uses full-size blocks so the sender is still busy
      // when the receiver starts holding off.
      write_reg(CfgWidth, (ph == 2) ? CfgDataW'(MaxDim) : pick_dim());
      write_reg(CfgHeight, (ph == 2) ? CfgDataW'(MaxDim) : pick_dim());
      if (ph == 2) hold_req = 1'b1;
      for (nb = 0; nb < BlocksPerPhase; nb++) begin
        blk = rand_block();
        send_block(blk, hold_req);
        decode_block(blk);
      end
    end

    drain_pixels();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dxtbd_pkg.sv
design/dxtbd_palette.sv
design/dxtbd_lane.sv
design/dxtbd_merge.sv
design/dxt_block_decoder_unit.sv
tb/sv/dxt_block_decoder_unit_tb.sv
